[design/latency_histogram_percentile_top_macros.svh]
// ----------------------------------------------------------------------------
// Latency histogram assertion macros
// Short forms for the clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_PERCENTILE_TOP_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define LHP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define LHP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lhp_pkg.sv]
// ----------------------------------------------------------------------------
// Latency histogram package
// Shared widths, action codes, limits and types.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int DEF_BUCKET_US  = 100;
    localparam int DEF_TOP_BUCKET = 1023;

    localparam int ACTION_W = 3;
    localparam int LAT_W    = 32;
    localparam int PCT_W    = 17;
    localparam int RESP_W   = 42;
    localparam int CNT_W    = 48;
    localparam int BKT_W    = 32;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [PCT_W-1:0]    pct_t;
    typedef logic [RESP_W-1:0]   resp_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // Item action codes
    localparam action_t ACT_LATENCY     = 3'd0;
    localparam action_t ACT_ERROR       = 3'd1;
    localparam action_t ACT_REJECT      = 3'd2;
    localparam action_t ACT_LOAD_REJECT = 3'd3;
    localparam action_t ACT_DRAIN       = 3'd4;

    // Saturation limits
    localparam logic [63:0] PCT_MAX  = 64'h1_FFFF;
    localparam logic [63:0] RESP_MAX = 64'h3FF_FFFF_FFFF;

endpackage

[design/latency_histogram_percentile_top.sv]
// ----------------------------------------------------------------------------
// Latency histogram with nearest-rank percentiles
// Buckets latency items into two histograms, counts error and rejection
// items, and on a drain reports p50/p99 of both histograms and clears them.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  command  | start / busy           | action, latency_us, accepted
//  result   | done (1-cycle strobe)  | p50_us, p99_us, ok_p50_us, ok_p99_us,
//           |                        | response_total, error_total,
//           |                        | rejection_total, load_rejection_total
//
//  Error, rejection, load rejection and unknown items never raise busy.
//  A latency item keeps busy high for two passes through the shared
//  multiplier for the bucket divide, a correction step, then a read and a
//  write of the bucket memories.
//  A drain keeps busy high for one memory sweep at one bucket per cycle
//  plus four bound multiplies; done pulses at its end.
//  After reset the block sweeps zeros into both memories with busy high.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_top #(
    parameter int BUCKET_US  = lhp_pkg::DEF_BUCKET_US,
    parameter int TOP_BUCKET = lhp_pkg::DEF_TOP_BUCKET
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lhp_pkg::action_t action,
    input  logic [31:0]      latency_us,
    input  logic             accepted,
    output logic             done,
    output lhp_pkg::pct_t    p50_us,
    output lhp_pkg::pct_t    p99_us,
    output lhp_pkg::pct_t    ok_p50_us,
    output lhp_pkg::pct_t    ok_p99_us,
    output lhp_pkg::resp_t   response_total,
    output lhp_pkg::cnt_t    error_total,
    output lhp_pkg::cnt_t    rejection_total,
    output lhp_pkg::cnt_t    load_rejection_total
);

    import lhp_pkg::*;

    localparam int NB      = TOP_BUCKET + 1;
    localparam int IDX_W   = (NB > 1) ? $clog2(NB) : 1;
    localparam int SCAN_W  = IDX_W + 1;
    localparam int TOT_W   = BKT_W + IDX_W;
    localparam int P99_W   = TOT_W + 7;
    localparam int TOTX_W  = (TOT_W > RESP_W) ? TOT_W : RESP_W;
    localparam int MULB_W  = LAT_W + 1;
    localparam int PROD_W  = LAT_W + MULB_W;

    localparam logic [MULB_W-1:0] RECIP    = MULB_W'((65'd1 << 32) / BUCKET_US);
    localparam logic [MULB_W-1:0] BKT_MUL  = MULB_W'(BUCKET_US);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TOP_BUCKET);
    localparam logic [BKT_W-1:0]  BKT_MAX  = '1;
    localparam cnt_t              CNT_MAX  = '1;

    // Sequencer states
    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_LMUL1 = 4'd2;
    localparam logic [3:0] ST_LMUL2 = 4'd3;
    localparam logic [3:0] ST_LFIX  = 4'd4;
    localparam logic [3:0] ST_LRD   = 4'd5;
    localparam logic [3:0] ST_LWR   = 4'd6;
    localparam logic [3:0] ST_DPREP = 4'd7;
    localparam logic [3:0] ST_DSCAN = 4'd8;
    localparam logic [3:0] ST_DMUL  = 4'd9;
    localparam logic [3:0] ST_DSAT  = 4'd10;
    localparam logic [3:0] ST_DOUT  = 4'd11;

    // Control registers
    logic [3:0]        state_reg, state_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              s1_vld_reg, s1_vld_next;
    logic              s2_vld_reg, s2_vld_next;
    logic [3:0]        found_reg, found_next;
    logic [1:0]        sel_reg, sel_next;
    logic              done_reg, done_next;
    cnt_t              err_cnt_reg, err_cnt_next;
    cnt_t              rej_cnt_reg, rej_cnt_next;
    cnt_t              load_cnt_reg, load_cnt_next;
    logic [TOT_W-1:0]  tall_reg, tall_next;
    logic [TOT_W-1:0]  tok_reg, tok_next;

    // Payload registers
    logic [LAT_W-1:0]  lat_reg, lat_next;
    logic              acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [LAT_W-1:0]  qest_reg, qest_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  s1_idx_reg, s1_idx_next;
    logic [IDX_W-1:0]  s2_idx_reg, s2_idx_next;
    logic [TOT_W-1:0]  seen_all_reg, seen_all_next;
    logic [TOT_W-1:0]  seen_ok_reg, seen_ok_next;
    logic [P99_W-1:0]  t99_all_reg, t99_all_next;
    logic [P99_W-1:0]  t99_ok_reg, t99_ok_next;
    logic [IDX_W-1:0]  pidx_reg [4];
    logic [IDX_W-1:0]  pidx_next [4];
    pct_t              pct_reg [4];
    pct_t              pct_next [4];
    resp_t             resp_reg, resp_next;
    cnt_t              err_out_reg, err_out_next;
    cnt_t              rej_out_reg, rej_out_next;
    cnt_t              load_out_reg, load_out_next;

    // Bucket memories
    logic [BKT_W-1:0]  mem_all [NB];
    logic [BKT_W-1:0]  mem_ok [NB];
    logic [BKT_W-1:0]  rd_all_reg;
    logic [BKT_W-1:0]  rd_ok_reg;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W-1:0]  mem_waddr;
    logic              all_we;
    logic              ok_we;
    logic [BKT_W-1:0]  all_wdata;
    logic [BKT_W-1:0]  ok_wdata;

    // Shared multiplier operands
    logic [LAT_W-1:0]  mul_a;
    logic [MULB_W-1:0] mul_b;

    // Datapath helpers
    logic              accept;
    logic [IDX_W-1:0]  scan_idx;
    logic              scan_issue;
    logic [LAT_W-1:0]  rem;
    logic              rem_ge;
    logic [LAT_W:0]    q_full;
    logic              all_inc;
    logic              ok_inc;
    logic [P99_W-1:0]  seen_all_x100;
    logic [P99_W-1:0]  seen_ok_x100;
    logic [3:0]        hit;
    logic              tot_zero;
    logic [TOTX_W-1:0] tall_x;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign scan_idx   = scan_cnt_reg[IDX_W-1:0];
    assign scan_issue = (scan_cnt_reg < SCAN_W'(NB));

    // Divide correction: estimate is at most one below the true quotient
    assign rem    = lat_reg - prod_reg[LAT_W-1:0];
    assign rem_ge = (rem >= LAT_W'(BUCKET_US));
    assign q_full = {1'b0, qest_reg} + {{LAT_W{1'b0}}, rem_ge};

    // Bucket increments saturate
    assign all_inc = (rd_all_reg != BKT_MAX);
    assign ok_inc  = acc_reg && (rd_ok_reg != BKT_MAX);

    // Running counts times 100 for the p99 test (64 + 32 + 4)
    assign seen_all_x100 = (P99_W'(seen_all_reg) << 6) + (P99_W'(seen_all_reg) << 5)
                         + (P99_W'(seen_all_reg) << 2);
    assign seen_ok_x100  = (P99_W'(seen_ok_reg) << 6) + (P99_W'(seen_ok_reg) << 5)
                         + (P99_W'(seen_ok_reg) << 2);

    // Rank tests: seen >= ceil(T/2) and seen >= ceil(99T/100)
    assign hit[0] = ({seen_all_reg, 1'b0} >= {1'b0, tall_reg});
    assign hit[1] = (seen_all_x100 >= t99_all_reg);
    assign hit[2] = ({seen_ok_reg, 1'b0} >= {1'b0, tok_reg});
    assign hit[3] = (seen_ok_x100 >= t99_ok_reg);

    assign tot_zero = sel_reg[1] ? (tok_reg == '0) : (tall_reg == '0);
    assign tall_x   = TOTX_W'(tall_reg);

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LMUL1:
            begin
                mul_a = lat_reg;
                mul_b = RECIP;
            end
            ST_LMUL2:
            begin
                mul_a = prod_reg[2*LAT_W-1:LAT_W];
                mul_b = BKT_MUL;
            end
            ST_DMUL:
            begin
                mul_a = LAT_W'(pidx_reg[sel_reg]) + LAT_W'(1);
                mul_b = BKT_MUL;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Memory port steering
    always_comb
    begin
        mem_raddr = (state_reg == ST_DSCAN) ? scan_idx : idx_reg;
        mem_waddr = (state_reg == ST_LWR) ? idx_reg : scan_idx;
        all_wdata = (state_reg == ST_LWR) ? (rd_all_reg + BKT_W'(1)) : '0;
        ok_wdata  = (state_reg == ST_LWR) ? (rd_ok_reg + BKT_W'(1)) : '0;
        unique case (state_reg)
            ST_CLR:
            begin
                all_we = 1'b1;
                ok_we  = 1'b1;
            end
            ST_DSCAN:
            begin
                all_we = scan_issue;
                ok_we  = scan_issue;
            end
            ST_LWR:
            begin
                all_we = all_inc;
                ok_we  = ok_inc;
            end
            default:
            begin
                all_we = 1'b0;
                ok_we  = 1'b0;
            end
        endcase
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        s1_vld_next   = 1'b0;
        s2_vld_next   = 1'b0;
        found_next    = found_reg;
        sel_next      = sel_reg;
        done_next     = 1'b0;
        err_cnt_next  = err_cnt_reg;
        rej_cnt_next  = rej_cnt_reg;
        load_cnt_next = load_cnt_reg;
        tall_next     = tall_reg;
        tok_next      = tok_reg;
        lat_next      = lat_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        qest_next     = qest_reg;
        idx_next      = idx_reg;
        s1_idx_next   = s1_idx_reg;
        s2_idx_next   = s2_idx_reg;
        seen_all_next = seen_all_reg;
        seen_ok_next  = seen_ok_reg;
        t99_all_next  = t99_all_reg;
        t99_ok_next   = t99_ok_reg;
        pidx_next     = pidx_reg;
        pct_next      = pct_reg;
        resp_next     = resp_reg;
        err_out_next  = err_out_reg;
        rej_out_next  = rej_out_reg;
        load_out_next = load_out_reg;

        unique case (state_reg)
            // Sweep zeros through both memories after reset
            ST_CLR:
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_idx == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Take an item; counter actions finish here
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (action == ACT_LATENCY)
                    begin
                        lat_next   = latency_us;
                        acc_next   = accepted;
                        state_next = ST_LMUL1;
                    end
                    else if (action == ACT_ERROR)
                    begin
                        if (err_cnt_reg != CNT_MAX)
                        begin
                            err_cnt_next = err_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (action == ACT_REJECT)
                    begin
                        if (rej_cnt_reg != CNT_MAX)
                        begin
                            rej_cnt_next = rej_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (action == ACT_LOAD_REJECT)
                    begin
                        if (load_cnt_reg != CNT_MAX)
                        begin
                            load_cnt_next = load_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (action == ACT_DRAIN)
                    begin
                        state_next = ST_DPREP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Quotient estimate by reciprocal
            ST_LMUL1:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = ST_LMUL2;
            end

            // Estimate times bucket width, for the remainder
            ST_LMUL2:
            begin
                qest_next  = prod_reg[2*LAT_W-1:LAT_W];
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = ST_LFIX;
            end

            // Correct the quotient and clamp to the overflow bucket
            ST_LFIX:
            begin
                if (q_full > (LAT_W+1)'(TOP_BUCKET))
                begin
                    idx_next = LAST_IDX;
                end
                else
                begin
                    idx_next = q_full[IDX_W-1:0];
                end
                state_next = ST_LRD;
            end

            // Read both buckets
            ST_LRD:
            begin
                state_next = ST_LWR;
            end

            // Write back the bumped buckets and track totals
            ST_LWR:
            begin
                if (all_inc)
                begin
                    tall_next = tall_reg + TOT_W'(1);
                end
                if (ok_inc)
                begin
                    tok_next = tok_reg + TOT_W'(1);
                end
                state_next = ST_IDLE;
            end

            // Form 99*T for both histograms and arm the sweep
            ST_DPREP:
            begin
                t99_all_next  = (P99_W'(tall_reg) << 6) + (P99_W'(tall_reg) << 5)
                              + (P99_W'(tall_reg) << 1) + P99_W'(tall_reg);
                t99_ok_next   = (P99_W'(tok_reg) << 6) + (P99_W'(tok_reg) << 5)
                              + (P99_W'(tok_reg) << 1) + P99_W'(tok_reg);
                scan_cnt_next = '0;
                seen_all_next = '0;
                seen_ok_next  = '0;
                found_next    = '0;
                state_next    = ST_DSCAN;
            end

            // Read and clear each bucket, accumulate, test the ranks
            ST_DSCAN:
            begin
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
                s1_vld_next = scan_issue;
                s1_idx_next = scan_idx;
                if (s1_vld_reg)
                begin
                    seen_all_next = seen_all_reg + TOT_W'(rd_all_reg);
                    seen_ok_next  = seen_ok_reg + TOT_W'(rd_ok_reg);
                end
                s2_vld_next = s1_vld_reg;
                s2_idx_next = s1_idx_reg;
                if (s2_vld_reg)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (!found_reg[i] && hit[i])
                        begin
                            found_next[i] = 1'b1;
                            pidx_next[i]  = s2_idx_reg;
                        end
                    end
                    if (s2_idx_reg == LAST_IDX)
                    begin
                        sel_next   = '0;
                        state_next = ST_DMUL;
                    end
                end
            end

            // Bucket upper bound for one percentile
            ST_DMUL:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = ST_DSAT;
            end

            // Saturate, or zero for an empty histogram
            ST_DSAT:
            begin
                if (tot_zero)
                begin
                    pct_next[sel_reg] = '0;
                end
                else if (prod_reg > PROD_W'(PCT_MAX))
                begin
                    pct_next[sel_reg] = PCT_MAX[PCT_W-1:0];
                end
                else
                begin
                    pct_next[sel_reg] = prod_reg[PCT_W-1:0];
                end
                if (sel_reg == 2'd3)
                begin
                    state_next = ST_DOUT;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_DMUL;
                end
            end

            // Present the report and reset the totals and the rejection count
            ST_DOUT:
            begin
                if (tall_x > TOTX_W'(RESP_MAX))
                begin
                    resp_next = RESP_MAX[RESP_W-1:0];
                end
                else
                begin
                    resp_next = tall_x[RESP_W-1:0];
                end
                err_out_next  = err_cnt_reg;
                rej_out_next  = rej_cnt_reg;
                load_out_next = load_cnt_reg;
                rej_cnt_next  = '0;
                tall_next     = '0;
                tok_next      = '0;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            scan_cnt_reg <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            found_reg    <= '0;
            sel_reg      <= '0;
            done_reg     <= 1'b0;
            err_cnt_reg  <= '0;
            rej_cnt_reg  <= '0;
            load_cnt_reg <= '0;
            tall_reg     <= '0;
            tok_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s2_vld_next;
            found_reg    <= found_next;
            sel_reg      <= sel_next;
            done_reg     <= done_next;
            err_cnt_reg  <= err_cnt_next;
            rej_cnt_reg  <= rej_cnt_next;
            load_cnt_reg <= load_cnt_next;
            tall_reg     <= tall_next;
            tok_reg      <= tok_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lat_reg      <= lat_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        qest_reg     <= qest_next;
        idx_reg      <= idx_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        seen_all_reg <= seen_all_next;
        seen_ok_reg  <= seen_ok_next;
        t99_all_reg  <= t99_all_next;
        t99_ok_reg   <= t99_ok_next;
        pidx_reg     <= pidx_next;
        pct_reg      <= pct_next;
        resp_reg     <= resp_next;
        err_out_reg  <= err_out_next;
        rej_out_reg  <= rej_out_next;
        load_out_reg <= load_out_next;
    end

    // Bucket memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (all_we)
        begin
            mem_all[mem_waddr] <= all_wdata;
        end
        if (ok_we)
        begin
            mem_ok[mem_waddr] <= ok_wdata;
        end
        rd_all_reg <= mem_all[mem_raddr];
        rd_ok_reg  <= mem_ok[mem_raddr];
    end

    // Result ports
    assign done                 = done_reg;
    assign p50_us               = pct_reg[0];
    assign p99_us               = pct_reg[1];
    assign ok_p50_us            = pct_reg[2];
    assign ok_p99_us            = pct_reg[3];
    assign response_total       = resp_reg;
    assign error_total          = err_out_reg;
    assign rejection_total      = rej_out_reg;
    assign load_rejection_total = load_out_reg;

endmodule

[design/lhp_checker.sv]
// ----------------------------------------------------------------------------
// Latency histogram port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "latency_histogram_percentile_top_macros.svh"

module lhp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input lhp_pkg::action_t action,
    input logic             done,
    input lhp_pkg::pct_t    p50_us,
    input lhp_pkg::pct_t    p99_us,
    input lhp_pkg::pct_t    ok_p50_us,
    input lhp_pkg::pct_t    ok_p99_us
);

    import lhp_pkg::*;

    logic take;

    assign take = start && !busy;

    // A report only closes a busy stretch, and the block is free with it
    `LHP_ASSERT_IMP(a_done_ends_work, clk, rst_n, done, !busy && $past(busy), "stray done")

    // Counter items finish at once and report nothing
    `LHP_ASSERT_NXT(a_count_quick, clk, rst_n,
        take && (action == ACT_ERROR || action == ACT_REJECT || action == ACT_LOAD_REJECT),
        !busy && !done, "counter item held the block")

    // A drain always sets the block to work
    `LHP_ASSERT_NXT(a_drain_busy, clk, rst_n, take && action == ACT_DRAIN, busy,
        "drain not started")

    // Median never lies above the 99th percentile
    `LHP_ASSERT_IMP(a_pct_order, clk, rst_n, done,
        p50_us <= p99_us && ok_p50_us <= ok_p99_us, "percentiles out of order")

endmodule

bind latency_histogram_percentile_top lhp_checker u_lhp_checker (.*);
